// ===== rtl/calendar_fields_to_tick_count_top_macros.svh =====
// Assertion macros for the calendar to tick count converter.
// Included by the top level; depends on clk and rst_n in the including scope.
`ifndef CALENDAR_FIELDS_TO_TICK_COUNT_TOP_MACROS_SVH
`define CALENDAR_FIELDS_TO_TICK_COUNT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define CFTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CFTC_ASSERT(lbl, prop, msg)
`define CFTC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/cftc_pkg.sv =====
// Package for the calendar to tick count converter: word types, pipeline
// control struct, range limits and the month offset table. No dependencies.
package cftc_pkg;

  typedef struct packed {
    logic [15:0] year;
    logic [15:0] month;
    logic [15:0] day;
    logic [15:0] hour;
    logic [15:0] minute;
    logic [15:0] second;
    logic [15:0] millisecond;
  } in_word_t;

  typedef struct packed {
    logic [62:0] ticks;
    logic        valid_res;
  } out_word_t;

  localparam int NUM_STAGES = 6;

  localparam int ST_FIELDS = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_YEARS  = 2;
  localparam int ST_DAYS   = 3;
  localparam int ST_TOTAL  = 4;
  localparam int ST_OUT    = 5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

  localparam logic [15:0] YEAR_FIRST  = 16'd1601;
  localparam logic [15:0] YEAR_BASE   = 16'd1600;
  localparam logic [15:0] YEAR_LAST   = 16'd30827;
  localparam logic [15:0] MONTH_LAST  = 16'd12;
  localparam logic [15:0] DAY_LAST    = 16'd32;
  localparam logic [15:0] HOUR_LAST   = 16'd23;
  localparam logic [15:0] MINUTE_LAST = 16'd59;
  localparam logic [15:0] SECOND_LAST = 16'd60;
  localparam logic [15:0] MS_LAST     = 16'd999;

  localparam logic [49:0] MS_PER_DAY   = 50'd86400000;
  localparam logic [62:0] TICKS_PER_MS = 63'd10000;

  // Reciprocal of 25 scaled by 2^17, exact for dividends below 8192.
  localparam logic [12:0] DIV25_MUL   = 13'd5243;
  localparam int          DIV25_SHIFT = 17;

  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/calendar_fields_to_tick_count_top.sv =====
// Calendar date and time to 100 ns ticks since 1601-01-01, six-stage pipeline.
// Throughput is one word per cycle unless out_stall holds the output stage.
// The final 50 by 14 bit scaling sets the depth.
// Synchronous active-low reset clears all stage valid bits; data is not reset.
// Depends on cftc_pkg, cftc_ctrl, cftc_date, cftc_tod and the macros header.
`include "calendar_fields_to_tick_count_top_macros.svh"

module calendar_fields_to_tick_count_top import cftc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  pipe_ctrl_t  ctrl;
  logic [23:0] days;
  logic        ok;
  logic [26:0] tod_ms;

  logic        ok4_r;
  logic [49:0] total4_r, total4_nxt;
  out_word_t   out_r, out_nxt;

  cftc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  cftc_date u_date (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_data (in_data),
    .days    (days),
    .ok      (ok)
  );

  cftc_tod u_tod (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_data (in_data),
    .tod_ms  (tod_ms)
  );

  always_comb begin
    total4_nxt = 50'(days) * MS_PER_DAY + 50'(tod_ms);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_TOTAL]) begin
      ok4_r    <= ok;
      total4_r <= total4_nxt;
    end
  end

  always_comb begin
    out_nxt.valid_res = ok4_r;
    out_nxt.ticks     = ok4_r ? 63'(63'(total4_r) * TICKS_PER_MS) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = !ctrl.en[ST_FIELDS];
  assign out_valid = ctrl.vld[ST_OUT];
  assign out_data  = out_r;

  `CFTC_ASSERT(a_invalid_is_zero, out_valid && !out_data.valid_res |-> out_data.ticks == 63'd0, "invalid word carries nonzero ticks")
  `CFTC_ASSERT(a_no_stall_when_free, !out_stall |-> !in_stall, "input stalled while output is free")
  `CFTC_ASSERT_NEVER(a_accept_when_full, (&ctrl.vld) && out_stall && !in_stall, "input taken while pipeline is full")

endmodule

// ===== rtl/cftc_ctrl.sv =====
// Valid bits and per-stage load enables of the converter pipeline.
// Depends on cftc_pkg.
module cftc_ctrl import cftc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctrl.en  = en;
  assign ctrl.vld = vld_r;

endmodule

// ===== rtl/cftc_date.sv =====
// Date path: range checks, whole-year days with leap corrections, month
// offset and day of month, over the first four stages. Depends on cftc_pkg.
module cftc_date import cftc_pkg::*; (
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  in_word_t    in_data,
  output logic [23:0] days,
  output logic        ok
);

  logic        ok0_r, ok0_nxt;
  logic [14:0] n0_r, n0_nxt;
  logic [14:0] m0_r, m0_nxt;
  logic [3:0]  mi0_r, mi0_nxt;
  logic [4:0]  dm0_r, dm0_nxt;

  logic        ok1_r;
  logic [12:0] q4n1_r, q4n1_nxt;
  logic [23:0] n365_1_r, n365_1_nxt;
  logic [8:0]  q100n1_r, q100n1_nxt;
  logic [12:0] q4m1_r, q4m1_nxt;
  logic [1:0]  mlo1_r, mlo1_nxt;
  logic [8:0]  q100m1_r, q100m1_nxt;
  logic [3:0]  mi1_r;
  logic [4:0]  dm1_r;
  logic [25:0] prod_n, prod_m;

  logic        ok2_r;
  logic [23:0] yd2_r, yd2_nxt;
  logic        leap2_r, leap2_nxt;
  logic [3:0]  mi2_r;
  logic [4:0]  dm2_r;

  logic        ok3_r;
  logic [23:0] days3_r, days3_nxt;

  always_comb begin
    ok0_nxt = (in_data.year >= YEAR_FIRST) && (in_data.year <= YEAR_LAST) &&
              (in_data.month >= 16'd1) && (in_data.month <= MONTH_LAST) &&
              (in_data.day >= 16'd1) && (in_data.day <= DAY_LAST) &&
              (in_data.hour <= HOUR_LAST) && (in_data.minute <= MINUTE_LAST) &&
              (in_data.second <= SECOND_LAST) && (in_data.millisecond <= MS_LAST);
    n0_nxt  = 15'(in_data.year - YEAR_FIRST);
    m0_nxt  = 15'(in_data.year - YEAR_BASE);
    mi0_nxt = 4'(in_data.month - 16'd1);
    dm0_nxt = 5'(in_data.day - 16'd1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_FIELDS]) begin
      ok0_r <= ok0_nxt;
      n0_r  <= n0_nxt;
      m0_r  <= m0_nxt;
      mi0_r <= mi0_nxt;
      dm0_r <= dm0_nxt;
    end
  end

  // Division by 100 is a shift by two followed by a reciprocal multiply by 1/25.
  always_comb begin
    q4n1_nxt   = n0_r[14:2];
    q4m1_nxt   = m0_r[14:2];
    mlo1_nxt   = m0_r[1:0];
    n365_1_nxt = 24'(n0_r) * 24'd365;
    prod_n     = 26'(q4n1_nxt) * 26'(DIV25_MUL);
    prod_m     = 26'(q4m1_nxt) * 26'(DIV25_MUL);
    q100n1_nxt = 9'(prod_n >> DIV25_SHIFT);
    q100m1_nxt = 9'(prod_m >> DIV25_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_MUL]) begin
      ok1_r    <= ok0_r;
      q4n1_r   <= q4n1_nxt;
      n365_1_r <= n365_1_nxt;
      q100n1_r <= q100n1_nxt;
      q4m1_r   <= q4m1_nxt;
      mlo1_r   <= mlo1_nxt;
      q100m1_r <= q100m1_nxt;
      mi1_r    <= mi0_r;
      dm1_r    <= dm0_r;
    end
  end

  // The leap test is taken on the year offset from 1600.
  always_comb begin
    yd2_nxt   = n365_1_r + 24'(q4n1_r) - 24'(q100n1_r) + 24'(q100n1_r[8:2]);
    leap2_nxt = (mlo1_r == 2'd0) &&
                ((q4m1_r != 13'(13'(q100m1_r) * 13'd25)) || (q100m1_r[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_YEARS]) begin
      ok2_r   <= ok1_r;
      yd2_r   <= yd2_nxt;
      leap2_r <= leap2_nxt;
      mi2_r   <= mi1_r;
      dm2_r   <= dm1_r;
    end
  end

  always_comb begin
    days3_nxt = yd2_r + 24'(days_before(leap2_r, mi2_r)) + 24'(dm2_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_DAYS]) begin
      ok3_r   <= ok2_r;
      days3_r <= days3_nxt;
    end
  end

  assign days = days3_r;
  assign ok   = ok3_r;

endmodule

// ===== rtl/cftc_tod.sv =====
// Time-of-day path: milliseconds since midnight over the first four stages.
// Depends on cftc_pkg.
module cftc_tod import cftc_pkg::*; (
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  in_word_t    in_data,
  output logic [26:0] tod_ms
);

  logic [10:0] hm0_r, hm0_nxt;
  logic [5:0]  s0_r;
  logic [9:0]  ms0_r;

  logic [16:0] hms1_r, hms1_nxt;
  logic [9:0]  ms1_r;

  logic [26:0] tod2_r, tod2_nxt;
  logic [26:0] tod3_r;

  always_comb begin
    hm0_nxt = 11'(in_data.hour[4:0]) * 11'd60 + 11'(in_data.minute[5:0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_FIELDS]) begin
      hm0_r <= hm0_nxt;
      s0_r  <= in_data.second[5:0];
      ms0_r <= in_data.millisecond[9:0];
    end
  end

  always_comb begin
    hms1_nxt = 17'(hm0_r) * 17'd60 + 17'(s0_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_MUL]) begin
      hms1_r <= hms1_nxt;
      ms1_r  <= ms0_r;
    end
  end

  always_comb begin
    tod2_nxt = 27'(hms1_r) * 27'd1000 + 27'(ms1_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_YEARS]) begin
      tod2_r <= tod2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_DAYS]) begin
      tod3_r <= tod2_r;
    end
  end

  assign tod_ms = tod3_r;

endmodule

// ===== tb/sv/tb_calendar_fields_to_tick_count_top.sv =====
// Testbench for calendar_fields_to_tick_count_top: feeds calendar words under random idle
// and stall bursts and compares every tick count word with a predictor kept here.
// Depends on cftc_pkg and the converter RTL only.
module tb_calendar_fields_to_tick_count_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cftc_pkg::*;

  localparam int N_RANDOM     = 1130;
  localparam int CALM_TAIL    = 120;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int unsigned FIELD_LO [7] = '{1601, 1, 1, 0, 0, 0, 0};
  localparam int unsigned FIELD_HI [7] = '{30827, 12, 32, 23, 59, 60, 999};
  localparam int unsigned DAYS_BEFORE_MONTH [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t  pending_dates [$];
  out_word_t expected_ticks [$];
  int        in_count = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  logic      in_took = 1'b0;
  logic      calm = 1'b0;
  int        gap_left = 0;
  int        run_left = 0;
  int        stall_left = 0;
  int        free_left = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  calendar_fields_to_tick_count_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_word_t tick_count_of(in_word_t w);
    out_word_t        r;
    int unsigned      n;
    int unsigned      days;
    int unsigned      yb;
    int unsigned      ms_of_day;
    longint unsigned  total_ms;
    longint unsigned  ticks;
    r = '0;
    if (w.year < 16'd1601 || w.year > 16'd30827 || w.month < 16'd1 || w.month > 16'd12 ||
        w.day < 16'd1 || w.day > 16'd32 || w.hour > 16'd23 || w.minute > 16'd59 ||
        w.second > 16'd60 || w.millisecond > 16'd999) begin
      return r;
    end
    n = w.year - 1601;
    days = n * 365 + n / 4 - n / 100 + n / 400;
    yb = w.year - 1600;
    days += DAYS_BEFORE_MONTH[w.month - 1];
    if (w.month > 2 && (yb % 400 == 0 || (yb % 100 != 0 && yb % 4 == 0))) begin
      days += 1;
    end
    days += w.day - 1;
    ms_of_day = ((int'(w.hour) * 60 + int'(w.minute)) * 60 + int'(w.second)) * 1000 +
                int'(w.millisecond);
    total_ms = longint'(days) * 64'd86400000 + longint'(ms_of_day);
    ticks = total_ms * 64'd10000;
    r.ticks = ticks[62:0];
    r.valid_res = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] value_in(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0: return lo[15:0];
      1: return hi[15:0];
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] value_out(int unsigned lo, int unsigned hi);
    if (lo > 0 && $urandom_range(0, 1) == 0) begin
      return 16'($urandom_range(lo - 1, 0));
    end
    if ($urandom_range(0, 3) == 0) begin
      return 16'(hi + 1);
    end
    return 16'($urandom_range(65535, hi + 1));
  endfunction

  task automatic add_date(int y, int mo, int d, int h, int mi, int s, int ms);
    in_word_t w;
    w.year = y[15:0];
    w.month = mo[15:0];
    w.day = d[15:0];
    w.hour = h[15:0];
    w.minute = mi[15:0];
    w.second = s[15:0];
    w.millisecond = ms[15:0];
    pending_dates = {pending_dates, w};
  endtask

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Sender: holds a stalled word, otherwise sends runs of words separated by idle bursts.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      calm <= (pending_dates.size() < CALM_TAIL);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_dates.size() == 0) begin
        in_valid <= 1'b0;
      end else if (run_left == 0 && !calm && $urandom_range(0, 1) == 0) begin
        run_left = $urandom_range(40, 1);
        gap_left = $urandom_range(9, 0);
        in_valid <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(40, 1);
        end else begin
          run_left--;
        end
        in_valid <= 1'b1;
        in_data <= pending_dates.pop_front();
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off to fill the pipeline, none at the end.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && in_count >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(9, 0);
        out_stall <= 1'b1;
      end else begin
        free_left = $urandom_range(40, 0);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          note_mismatch("word with none pending, ticks", 64'd0, 64'(out_data.ticks));
        end else begin
          want = expected_ticks.pop_front();
          if (out_data.ticks !== want.ticks) begin
            note_mismatch("ticks", 64'(want.ticks), 64'(out_data.ticks));
          end
          if (out_data.valid_res !== want.valid_res) begin
            note_mismatch("valid_res", 64'(want.valid_res), 64'(out_data.valid_res));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_ticks = {expected_ticks, tick_count_of(in_data)};
        in_count <= in_count + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[calendar_fields_to_tick_count_top] ERROR");
    $finish;
  end

  initial begin
    logic [111:0] flat;
    int unsigned  kind;
    int unsigned  k;
    int           total;
    add_date(1601, 1, 1, 0, 0, 0, 0);
    add_date(30827, 12, 32, 23, 59, 60, 999);
    add_date(2000, 2, 29, 12, 30, 45, 500);
    add_date(2000, 3, 1, 0, 0, 0, 0);
    add_date(1900, 3, 1, 0, 0, 0, 0);
    add_date(2024, 2, 31, 6, 7, 8, 9);
    add_date(1700, 12, 32, 0, 0, 0, 0);
    add_date(2023, 12, 31, 23, 59, 60, 999);
    add_date(1600, 12, 31, 23, 59, 59, 999);
    add_date(30828, 1, 1, 0, 0, 0, 0);
    add_date(0, 0, 0, 0, 0, 0, 0);
    add_date(65535, 65535, 65535, 65535, 65535, 65535, 65535);
    add_date(2000, 0, 1, 0, 0, 0, 0);
    add_date(2000, 13, 1, 0, 0, 0, 0);
    add_date(2000, 1, 0, 0, 0, 0, 0);
    add_date(2000, 1, 33, 0, 0, 0, 0);
    add_date(2000, 1, 1, 24, 0, 0, 0);
    add_date(2000, 1, 1, 0, 60, 0, 0);
    add_date(2000, 1, 1, 0, 0, 61, 0);
    add_date(2000, 1, 1, 0, 0, 0, 1000);
    add_date(30827, 1, 1, 0, 0, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(99, 0);
      for (int f = 0; f < 7; f++) begin
        flat[111 - 16 * f -: 16] = value_in(FIELD_LO[f], FIELD_HI[f]);
      end
      if (kind < 10) begin
        flat[111 -: 16] = 16'(1600 + 100 * $urandom_range(292, 1));
      end
      if (kind >= 92) begin
        for (int f = 0; f < 7; f++) begin
          flat[111 - 16 * f -: 16] = 16'($urandom);
        end
      end else if (kind >= 80) begin
        k = $urandom_range(6, 0);
        flat[111 - 16 * k -: 16] = value_out(FIELD_LO[k], FIELD_HI[k]);
      end
      pending_dates = {pending_dates, in_word_t'(flat)};
    end
    total = pending_dates.size();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (in_count < total) @(negedge clk);
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("[calendar_fields_to_tick_count_top] OK");
    end else begin
      $display("[calendar_fields_to_tick_count_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== calendar_fields_to_tick_count_top.f =====
+incdir+rtl
rtl/cftc_pkg.sv
rtl/cftc_ctrl.sv
rtl/cftc_date.sv
rtl/cftc_tod.sv
rtl/calendar_fields_to_tick_count_top.sv
tb/sv/tb_calendar_fields_to_tick_count_top.sv
